// ===== design/rotated_sprite_quad_batcher_assert.svh =====
// Assertion macros for the rotated sprite quad batcher.
`ifndef ROTATED_SPRITE_QUAD_BATCHER_ASSERT_SVH
`define ROTATED_SPRITE_QUAD_BATCHER_ASSERT_SVH
`ifndef SYNTH
`define RSQB_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rsqb assertion failed");
`define RSQB_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rsqb assertion failed");
`else
`define RSQB_ASSERT_IMP(label, clk, rst, ante, cons)
`define RSQB_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== design/rsqb_pkg.sv =====
// Shared types, constants and tables of the rotated sprite quad batcher.
package rsqb_pkg;

  localparam int POS_W   = 24;
  localparam int TEX_W   = 16;
  localparam int UV_W    = 16;
  localparam int RGBA_W  = 32;
  localparam int SLOT_W  = 13;
  localparam int ANG_W   = 16;
  localparam int OP_W    = 2;
  localparam int CFG_A_W = 1;

  localparam int TRIG_W     = 18;          // Q1.14 cos/sin with headroom
  localparam int TRIG_FRAC  = 14;
  localparam int CORDIC_N   = 14;
  localparam int ITER_W     = 4;
  localparam int CORDIC_X0  = 9949;        // 1/K scaled to Q1.14

  localparam int CTR_W      = POS_W + 2;   // 2*left + width + 1
  localparam int PROD_W     = POS_W + TRIG_W;
  localparam int ACC_W      = 44;
  localparam int OUT_SHIFT  = 15;
  localparam int RND_W      = ACC_W - OUT_SHIFT;

  localparam int BATCH_VERTICES_DEF = 4096;
  localparam int QUAD_VERTS         = 4;

  localparam logic [TEX_W-1:0] WHITE_TEX_RST   = '0;
  localparam logic [TEX_W-1:0] INVALID_TEX_RST = '1;

  localparam logic [OP_W-1:0] OP_DRAW  = 2'd0;
  localparam logic [OP_W-1:0] OP_BEGIN = 2'd1;
  localparam logic [OP_W-1:0] OP_END   = 2'd2;

  localparam logic KIND_VERTEX = 1'b0;
  localparam logic KIND_FLUSH  = 1'b1;

  localparam logic [CFG_A_W-1:0] REG_WHITE   = 1'b0;
  localparam logic [CFG_A_W-1:0] REG_INVALID = 1'b1;

  typedef struct packed {
    logic                     done;
    logic signed [TRIG_W-1:0] cos_q;
    logic signed [TRIG_W-1:0] sin_q;
  } trig_t;

  // atan(2^-i) in binary-angle units (65536 per turn)
  function automatic logic [ANG_W-3:0] atan_step(input logic [ITER_W-1:0] i);
    logic [ANG_W-3:0] v;
    case (i)
      4'd0:    v = 14'd8192;
      4'd1:    v = 14'd4836;
      4'd2:    v = 14'd2555;
      4'd3:    v = 14'd1297;
      4'd4:    v = 14'd651;
      4'd5:    v = 14'd326;
      4'd6:    v = 14'd163;
      4'd7:    v = 14'd81;
      4'd8:    v = 14'd41;
      4'd9:    v = 14'd20;
      4'd10:   v = 14'd10;
      4'd11:   v = 14'd5;
      4'd12:   v = 14'd3;
      4'd13:   v = 14'd1;
      default: v = 14'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== design/rsqb_cordic.sv =====
// Iterative CORDIC cosine/sine of a 16-bit binary angle, one step per cycle.
module rsqb_cordic import rsqb_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [ANG_W-1:0] angle,
  output trig_t            trig
);

  logic signed [TRIG_W-1:0] x, y;
  logic signed [ANG_W-1:0]  z;
  logic [1:0]               quad;
  logic [ITER_W-1:0]        iter;
  logic                     run;
  logic                     map;

  logic signed [TRIG_W-1:0] xs, ys, x_next, y_next;
  logic signed [ANG_W-1:0]  z_step, z_next;

  always_comb begin
    xs     = x >>> iter;
    ys     = y >>> iter;
    z_step = $signed({2'b00, atan_step(iter)});
    if (!z[ANG_W-1]) begin
      x_next = x - ys;
      y_next = y + xs;
      z_next = z - z_step;
    end else begin
      x_next = x + ys;
      y_next = y - xs;
      z_next = z + z_step;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run       <= 1'b0;
      map       <= 1'b0;
      trig.done <= 1'b0;
    end else begin
      if (start) begin
        x         <= TRIG_W'(CORDIC_X0);
        y         <= '0;
        z         <= $signed({2'b00, angle[ANG_W-3:0]});
        quad      <= angle[ANG_W-1:ANG_W-2];
        iter      <= '0;
        run       <= 1'b1;
        trig.done <= 1'b0;
      end else if (run) begin
        x         <= x_next;
        y         <= y_next;
        z         <= z_next;
        iter      <= iter + 1'b1;
        trig.done <= 1'b0;
        if (iter == ITER_W'(CORDIC_N - 1)) begin
          run <= 1'b0;
          map <= 1'b1;
        end
      end else if (map) begin
        map       <= 1'b0;
        trig.done <= 1'b1;
        // quadrant fold from the top two angle bits
        case (quad)
          2'd0: begin trig.cos_q <= x;  trig.sin_q <= y;  end
          2'd1: begin trig.cos_q <= -y; trig.sin_q <= x;  end
          2'd2: begin trig.cos_q <= -x; trig.sin_q <= -y; end
          default: begin trig.cos_q <= y; trig.sin_q <= -x; end
        endcase
      end else begin
        trig.done <= 1'b0;
      end
    end
  end

endmodule

// ===== design/rotated_sprite_quad_batcher.sv =====
// Top level of the rotated sprite quad batcher: command sequencer, shared MAC, result register.
//
// Takes sprite draw and frame begin/end commands and turns each draw into four
// rotated quad vertices, grouped into batches by texture. A draw naming the
// invalid texture id uses the white texture. If the texture differs from the
// bound one, or four more vertices would pass BATCH_VERTICES, a flush item
// (kind 1, slot = vertex count, batch_texture = old texture) goes out first,
// only when the batch holds vertices. Corners are rotated about the sprite
// centre by a 14-step CORDIC cos/sin (Q1.14), positions are Q16.8 rounded
// half up and saturated to 24 bits, uv is Q4.12 and the colour passes through.
// Triangle indices are implied by slot: s, s+1, s+2, s+2, s+3, s.
// Begin frame drops the batch without a flush and binds the invalid id; end
// frame flushes a non-empty batch with last = 1; op 3 is ignored.
// Throughput: one command at a time, cmd_ready only while idle. A draw runs
// through setup (which loads any flush item and starts the CORDIC), the
// CORDIC loop (load, 14 steps, quadrant fold, handoff), the four products on
// the shared 24x18 multiplier, then per vertex two accumulate steps and the
// result load. Begin frame is handled in idle; end frame with a non-empty
// batch passes through the flush state.
// A stalled result channel stretches the result loads.
// The result register lets the next step run while a result waits.
// Configuration (cfg_addr 0: white texture, 1: invalid id) is always ready
// and is meant to be written while the block is idle.
`include "rotated_sprite_quad_batcher_assert.svh"

module rotated_sprite_quad_batcher import rsqb_pkg::*; #(
  parameter int BATCH_VERTICES = BATCH_VERTICES_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  // configuration write channel
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_A_W-1:0]       cfg_addr,
  input  logic [TEX_W-1:0]         cfg_data,
  // command channel
  input  logic                     cmd_valid,
  output logic                     cmd_ready,
  input  logic [OP_W-1:0]          op,
  input  logic signed [POS_W-1:0]  pos_left,
  input  logic signed [POS_W-1:0]  pos_top,
  input  logic signed [POS_W-1:0]  width,
  input  logic signed [POS_W-1:0]  height,
  input  logic [TEX_W-1:0]         texture,
  input  logic [RGBA_W-1:0]        rgba,
  input  logic [ANG_W-1:0]         angle,
  input  logic signed [UV_W-1:0]   u_start,
  input  logic signed [UV_W-1:0]   v_start,
  input  logic signed [UV_W-1:0]   u_end,
  input  logic signed [UV_W-1:0]   v_end,
  // result channel
  output logic                     res_valid,
  input  logic                     res_ready,
  output logic                     kind,
  output logic signed [POS_W-1:0]  vert_x,
  output logic signed [POS_W-1:0]  vert_y,
  output logic signed [UV_W-1:0]   tex_u,
  output logic signed [UV_W-1:0]   tex_v,
  output logic [RGBA_W-1:0]        vert_rgba,
  output logic [SLOT_W-1:0]        slot,
  output logic [TEX_W-1:0]         batch_texture,
  output logic                     last
);

  // sequencer states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_FLUSH  = 3'd1;  // flush item out and CORDIC start; back to idle after an end-frame flush
  localparam logic [2:0] S_CORDIC = 3'd2;
  localparam logic [2:0] S_MUL    = 3'd3;  // w*c, w*s, h*c, h*s
  localparam logic [2:0] S_ADDA   = 3'd4;  // centre +- width term
  localparam logic [2:0] S_ADDB   = 3'd5;  // +- height term
  localparam logic [2:0] S_EMIT   = 3'd6;  // round, saturate, load result

  logic [2:0] state;

  // configuration and batch state
  logic [TEX_W-1:0]  white_id, sentinel_id;
  logic [TEX_W-1:0]  bound_texture;
  logic [SLOT_W-1:0] batch_count;

  // pending flush
  logic              flush_pend, flush_last;
  logic [SLOT_W-1:0] flush_cnt;
  logic [TEX_W-1:0]  flush_tex;

  // latched draw
  logic signed [POS_W-1:0] w_q, h_q;
  logic signed [UV_W-1:0]  u0_q, v0_q, u1_q, v1_q;
  logic [RGBA_W-1:0]       rgba_q;
  logic [ANG_W-1:0]        angle_q;
  logic signed [ACC_W-1:0] cx, cy;    // centre * 2^15 plus the rounding half

  // products and accumulators
  logic signed [PROD_W-1:0] p_wc, p_ws, p_hc, p_hs;
  logic signed [ACC_W-1:0]  ax, ay;
  logic [1:0]               mcnt, vcnt;

  trig_t trig;
  logic  cordic_start;

  // combinational helpers
  logic [TEX_W-1:0]         tex_r;
  logic                     rebind;
  logic signed [CTR_W-1:0]  ctr_x, ctr_y;
  logic signed [TRIG_W-1:0] mul_b;
  logic signed [POS_W-1:0]  mul_a;
  logic signed [PROD_W-1:0] mul_p;
  logic                     neg_w, neg_h;
  logic signed [ACC_W-1:0]  t_wc, t_ws, t_hc, t_hs;
  logic                     out_free, load_flush, load_vert;

  function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [ACC_W-1:0] a);
    logic signed [RND_W-1:0] r;
    logic [RND_W-POS_W:0]    hi;
    r  = a[ACC_W-1:OUT_SHIFT];
    hi = r[RND_W-1:POS_W-1];
    if (&hi || ~|hi) begin
      return r[POS_W-1:0];
    end else if (r[RND_W-1]) begin
      return {1'b1, {(POS_W-1){1'b0}}};
    end else begin
      return {1'b0, {(POS_W-1){1'b1}}};
    end
  endfunction

  rsqb_cordic u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (cordic_start),
    .angle (angle_q),
    .trig  (trig)
  );

  assign cfg_ready = 1'b1;
  assign cmd_ready = (state == S_IDLE);
  assign out_free  = !res_valid || res_ready;

  always_comb begin
    tex_r  = (texture == sentinel_id) ? white_id : texture;
    rebind = (bound_texture != tex_r) ||
             ((32'(batch_count) + 32'(QUAD_VERTS)) > 32'(BATCH_VERTICES));
    ctr_x  = {pos_left[POS_W-1], pos_left, 1'b0} + {{2{width[POS_W-1]}}, width}
             + CTR_W'(1);
    ctr_y  = {pos_top[POS_W-1], pos_top, 1'b0} + {{2{height[POS_W-1]}}, height}
             + CTR_W'(1);
  end

  // shared multiplier: mcnt[1] picks w/h, mcnt[0] picks cos/sin
  assign mul_a = mcnt[1] ? h_q : w_q;
  assign mul_b = mcnt[0] ? trig.sin_q : trig.cos_q;
  assign mul_p = mul_a * mul_b;

  // corner 0 (-w,h), 1 (w,h), 2 (w,-h), 3 (-w,-h)
  assign neg_w = (vcnt == 2'd0) || (vcnt == 2'd3);
  assign neg_h = (vcnt == 2'd0) || (vcnt == 2'd1);

  assign t_wc = {{(ACC_W-PROD_W){p_wc[PROD_W-1]}}, p_wc};
  assign t_ws = {{(ACC_W-PROD_W){p_ws[PROD_W-1]}}, p_ws};
  assign t_hc = {{(ACC_W-PROD_W){p_hc[PROD_W-1]}}, p_hc};
  assign t_hs = {{(ACC_W-PROD_W){p_hs[PROD_W-1]}}, p_hs};

  assign load_flush   = (state == S_FLUSH) && flush_pend && out_free;
  assign load_vert    = (state == S_EMIT) && out_free;
  assign cordic_start = (state == S_FLUSH) && (!flush_pend || out_free) && !flush_last;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      white_id    <= WHITE_TEX_RST;
      sentinel_id <= INVALID_TEX_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_addr)
        REG_WHITE:   white_id    <= cfg_data;
        REG_INVALID: sentinel_id <= cfg_data;
        default:     ;
      endcase
    end
  end

  // sequencer and batch state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      bound_texture <= INVALID_TEX_RST;
      batch_count   <= '0;
      flush_pend    <= 1'b0;
      flush_last    <= 1'b0;
      mcnt          <= '0;
      vcnt          <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            case (op)
              OP_DRAW: begin
                w_q        <= width;
                h_q        <= height;
                u0_q       <= u_start;
                v0_q       <= v_start;
                u1_q       <= u_end;
                v1_q       <= v_end;
                rgba_q     <= rgba;
                angle_q    <= angle;
                cx         <= {{(ACC_W-CTR_W-TRIG_FRAC){ctr_x[CTR_W-1]}}, ctr_x,
                               {TRIG_FRAC{1'b0}}};
                cy         <= {{(ACC_W-CTR_W-TRIG_FRAC){ctr_y[CTR_W-1]}}, ctr_y,
                               {TRIG_FRAC{1'b0}}};
                flush_last <= 1'b0;
                flush_pend <= rebind && (batch_count != '0);
                flush_cnt  <= batch_count;
                flush_tex  <= bound_texture;
                if (rebind) begin
                  batch_count   <= '0;
                  bound_texture <= tex_r;
                end
                state <= S_FLUSH;
              end
              OP_BEGIN: begin
                batch_count   <= '0;
                bound_texture <= sentinel_id;
              end
              OP_END: begin
                if (batch_count != '0) begin
                  flush_pend  <= 1'b1;
                  flush_last  <= 1'b1;
                  flush_cnt   <= batch_count;
                  flush_tex   <= bound_texture;
                  batch_count <= '0;
                  state       <= S_FLUSH;
                end
              end
              default: ;
            endcase
          end
        end
        S_FLUSH: begin
          if (!flush_pend || out_free) begin
            flush_pend <= 1'b0;
            flush_last <= 1'b0;
            state      <= flush_last ? S_IDLE : S_CORDIC;
          end
        end
        S_CORDIC: begin
          if (trig.done) begin
            mcnt  <= '0;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          case (mcnt)
            2'd0:    p_wc <= mul_p;
            2'd1:    p_ws <= mul_p;
            2'd2:    p_hc <= mul_p;
            default: p_hs <= mul_p;
          endcase
          mcnt <= mcnt + 1'b1;
          if (mcnt == 2'd3) begin
            vcnt  <= '0;
            state <= S_ADDA;
          end
        end
        S_ADDA: begin
          ax    <= neg_w ? (cx - t_wc) : (cx + t_wc);
          ay    <= neg_w ? (cy - t_ws) : (cy + t_ws);
          state <= S_ADDB;
        end
        S_ADDB: begin
          // x takes -dy*sin, y takes +dy*cos
          ax    <= neg_h ? (ax - t_hs) : (ax + t_hs);
          ay    <= neg_h ? (ay + t_hc) : (ay - t_hc);
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            batch_count <= batch_count + 1'b1;
            vcnt        <= vcnt + 1'b1;
            state       <= (vcnt == 2'd3) ? S_IDLE : S_ADDA;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load_flush || load_vert) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_flush) begin
      kind          <= KIND_FLUSH;
      vert_x        <= '0;
      vert_y        <= '0;
      tex_u         <= '0;
      tex_v         <= '0;
      vert_rgba     <= '0;
      slot          <= flush_cnt;
      batch_texture <= flush_tex;
      last          <= flush_last;
    end else if (load_vert) begin
      kind          <= KIND_VERTEX;
      vert_x        <= sat_pos(ax);
      vert_y        <= sat_pos(ay);
      tex_u         <= neg_w ? u0_q : u1_q;
      tex_v         <= neg_h ? v1_q : v0_q;
      vert_rgba     <= rgba_q;
      slot          <= batch_count;
      batch_texture <= bound_texture;
      last          <= (vcnt == 2'd3);
    end
  end

  // a flush never carries an empty batch
  `RSQB_ASSERT_IMP(a_flush_nonempty, clk, rst, res_valid && kind == KIND_FLUSH, slot != '0)
  // batches grow by whole quads, so the closing vertex of a draw sits on slot 3 mod 4
  `RSQB_ASSERT_IMP(a_last_slot, clk, rst, res_valid && kind == KIND_VERTEX,
                   last == (slot[1:0] == 2'b11))
  // a draw does not leave the sequencer idle: cmd_ready is low after it is taken
  `RSQB_ASSERT_NXT(a_draw_busy, clk, rst, cmd_valid && cmd_ready && op == OP_DRAW,
                   !cmd_ready)

endmodule
